[hw/rtl/rodf_pkg.sv]
`default_nettype none

package rodf_pkg;

  // Default fraction bit count of the fixed point ports and registers
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LENGTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIAL      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_X     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TDAMP      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NDAMP      = 4'd7;

  // Angle to phase: 2^32 / (2*pi), and pi with 30 fraction bits
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
  localparam logic [31:0]        PI_Q30       = 32'd3373259426;
  localparam logic [30:0]        TRIG_ONE     = 31'h4000_0000;

  // Series evaluation: one leading divide, then four multiply/divide rounds.
  // Divide by constant d is (p * m) >> sh with m = ceil(2^sh / d), exact for p < 2^30.
  localparam int RND_N = 4;
  localparam int S0_SH = 37;
  localparam int C0_SH = 37;
  localparam logic [30:0] S0_M = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [30:0] C0_M = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam int SIN_SH [RND_N] = '{36, 35, 33, 30};
  localparam int COS_SH [RND_N] = '{36, 35, 34, 31};
  localparam logic [30:0] SIN_M [RND_N] = '{
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6),
    31'((64'd1 << 30) / 64'd1)
  };
  localparam logic [30:0] COS_M [RND_N] = '{
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  // Sine/cosine unit latency in cycles
  localparam int TRIG_LAT = 5 + 2 * RND_N;

  typedef struct packed {
    logic signed [31:0] node1_x;
    logic signed [31:0] node1_y;
    logic signed [31:0] angle;
    logic signed [31:0] node2_x;
    logic signed [31:0] node2_y;
    logic signed [31:0] node1_vx;
    logic signed [31:0] node1_vy;
    logic signed [31:0] angle_rate;
    logic signed [31:0] node2_vx;
    logic signed [31:0] node2_vy;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_node1_x;
    logic signed [31:0] force_node1_y;
    logic signed [31:0] moment;
    logic signed [31:0] force_node2_x;
    logic signed [31:0] force_node2_y;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rod_element_force_top.sv]
`default_nettype none

// Channel   Ports                                   Transfer
// input     start, busy, in_data                    start high and busy low at a clock edge
// result    out_valid, out_data                     out_valid high for one cycle, always taken
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready both high
//
// One item enters every cycle; busy is always low and cfg_ready always high.
// Data pass through the sine/cosine unit (angle scale, fold, square,
// leading divide, four multiply/divide rounds, unfold) and then the force
// stages T1 to T8, one multiplier deep each.
// Reset clears the valid bits and loads the register defaults; the data
// path carries no reset. The receiver cannot stall, so the pipe always moves.

module rod_element_force_top #(
  parameter int FRAC_BITS = rodf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire rodf_pkg::in_t                      in_data,
  output logic                                    out_valid,
  output rodf_pkg::out_t                          out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rodf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  localparam int LAT = rodf_pkg::TRIG_LAT;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [30:0]        length_r;
  logic [30:0]        inv_length_r;
  logic [30:0]        axial_r;
  logic [30:0]        shear_r;
  logic signed [31:0] grav_x_r;
  logic signed [31:0] grav_y_r;
  logic [30:0]        tdamp_r;
  logic [30:0]        ndamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r     <= 31'(64'd1 << FRAC_BITS);
      inv_length_r <= 31'(64'd1 << FRAC_BITS);
      axial_r      <= '0;
      shear_r      <= '0;
      grav_x_r     <= '0;
      grav_y_r     <= '0;
      tdamp_r      <= '0;
      ndamp_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // Drop the top bit for the unsigned registers; ignore unknown indexes
      case (cfg_index)
        rodf_pkg::REG_LENGTH:     length_r     <= cfg_data[30:0];
        rodf_pkg::REG_INV_LENGTH: inv_length_r <= cfg_data[30:0];
        rodf_pkg::REG_AXIAL:      axial_r      <= cfg_data[30:0];
        rodf_pkg::REG_SHEAR:      shear_r      <= cfg_data[30:0];
        rodf_pkg::REG_GRAV_X:     grav_x_r     <= $signed(cfg_data);
        rodf_pkg::REG_GRAV_Y:     grav_y_r     <= $signed(cfg_data);
        rodf_pkg::REG_TDAMP:      tdamp_r      <= cfg_data[30:0];
        rodf_pkg::REG_NDAMP:      ndamp_r      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Registers as signed multiplier operands
  logic signed [63:0] length_s;
  logic signed [63:0] inv_length_s;
  logic signed [63:0] axial_s;
  logic signed [63:0] shear_s;
  logic signed [63:0] tdamp_s;
  logic signed [63:0] ndamp_s;

  assign length_s     = $signed(64'(length_r));
  assign inv_length_s = $signed(64'(inv_length_r));
  assign axial_s      = $signed(64'(axial_r));
  assign shear_s      = $signed(64'(shear_r));
  assign tdamp_s      = $signed(64'(tdamp_r));
  assign ndamp_s      = $signed(64'(ndamp_r));

  // ---------------------------------------------------------------
  // Input transfer: differences and the angle rate go into a delay line that
  // matches the sine/cosine unit; the angle goes into that unit
  // ---------------------------------------------------------------
  typedef struct packed {
    logic signed [31:0] dx0;
    logic signed [31:0] dx1;
    logic signed [31:0] dv0;
    logic signed [31:0] dv1;
    logic signed [31:0] w;
  } dly_t;

  logic in_xfer;
  dly_t dly_nxt;
  dly_t dly_r [0:LAT-1];

  assign in_xfer = start && !busy;

  assign dly_nxt.dx0 = rodf_pkg::sat32(64'(in_data.node2_x) - 64'(in_data.node1_x));
  assign dly_nxt.dx1 = rodf_pkg::sat32(64'(in_data.node2_y) - 64'(in_data.node1_y));
  assign dly_nxt.dv0 = rodf_pkg::sat32(64'(in_data.node2_vx) - 64'(in_data.node1_vx));
  assign dly_nxt.dv1 = rodf_pkg::sat32(64'(in_data.node2_vy) - 64'(in_data.node1_vy));
  assign dly_nxt.w   = in_data.angle_rate;

  always_ff @(posedge clk) begin
    dly_r[0] <= dly_nxt;
    for (int i = 1; i < LAT; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  logic               trig_valid;
  logic signed [31:0] sin_v;
  logic signed [31:0] cos_v;

  rodf_sincos #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_xfer),
    .angle    (in_data.angle),
    .out_valid(trig_valid),
    .sin_q    (sin_v),
    .cos_q    (cos_v)
  );

  dly_t al;
  assign al = dly_r[LAT-1];

  // ---------------------------------------------------------------
  // T1: rotate the differences into the element frame (products)
  // ---------------------------------------------------------------
  logic               v1_r;
  logic signed [63:0] p_cx0_r, p_sx1_r, p_cx1_r, p_sx0_r;
  logic signed [63:0] p_cv0_r, p_sv1_r, p_cv1_r, p_sv0_r;
  logic signed [31:0] w1_r, s1_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= trig_valid;
    end
    p_cx0_r <= 64'(cos_v) * 64'(al.dx0);
    p_sx1_r <= 64'(sin_v) * 64'(al.dx1);
    p_cx1_r <= 64'(cos_v) * 64'(al.dx1);
    p_sx0_r <= 64'(sin_v) * 64'(al.dx0);
    p_cv0_r <= 64'(cos_v) * 64'(al.dv0);
    p_sv1_r <= 64'(sin_v) * 64'(al.dv1);
    p_cv1_r <= 64'(cos_v) * 64'(al.dv1);
    p_sv0_r <= 64'(sin_v) * 64'(al.dv0);
    w1_r    <= al.w;
    s1_r    <= sin_v;
    c1_r    <= cos_v;
  end

  // ---------------------------------------------------------------
  // T2: axial, shear, tangential and normal components
  // ---------------------------------------------------------------
  logic               v2_r;
  logic signed [31:0] ax2_r, sh2_r, vt2_r, vn2_r, w2_r, s2_r, c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    ax2_r <= rodf_pkg::sat32((p_cx0_r + p_sx1_r) >>> 30);
    sh2_r <= rodf_pkg::sat32((p_cx1_r - p_sx0_r) >>> 30);
    vt2_r <= rodf_pkg::sat32((p_cv0_r + p_sv1_r) >>> 30);
    vn2_r <= rodf_pkg::sat32((p_cv1_r - p_sv0_r) >>> 30);
    w2_r  <= w1_r;
    s2_r  <= s1_r;
    c2_r  <= c1_r;
  end

  // ---------------------------------------------------------------
  // T3: stiffness and inverse length products
  // ---------------------------------------------------------------
  logic signed [31:0] strain_nxt;
  logic               v3_r;
  logic signed [63:0] pa3_r, ps3_r, pvt3_r, pvn3_r;
  logic signed [31:0] ax3_r, sh3_r, w3_r, s3_r, c3_r;

  assign strain_nxt = rodf_pkg::sat32(64'(ax2_r) - length_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    pa3_r  <= 64'(strain_nxt) * axial_s;
    ps3_r  <= 64'(sh2_r) * shear_s;
    pvt3_r <= 64'(vt2_r) * inv_length_s;
    pvn3_r <= 64'(vn2_r) * inv_length_s;
    ax3_r  <= ax2_r;
    sh3_r  <= sh2_r;
    w3_r   <= w2_r;
    s3_r   <= s2_r;
    c3_r   <= c2_r;
  end

  // ---------------------------------------------------------------
  // T4: elastic forces and strain rates
  // ---------------------------------------------------------------
  logic               v4_r;
  logic signed [31:0] ft4_r, fn4_r, vtl4_r, vnl4_r, ax4_r, sh4_r, s4_r, c4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    ft4_r  <= rodf_pkg::sat32(pa3_r >>> FRAC_BITS);
    fn4_r  <= rodf_pkg::sat32(ps3_r >>> FRAC_BITS);
    vtl4_r <= rodf_pkg::sat32(pvt3_r >>> FRAC_BITS);
    // Normal rate subtracts the angle rate before saturation
    vnl4_r <= rodf_pkg::sat32((pvn3_r >>> FRAC_BITS) - 64'(w3_r));
    ax4_r  <= ax3_r;
    sh4_r  <= sh3_r;
    s4_r   <= s3_r;
    c4_r   <= c3_r;
  end

  // ---------------------------------------------------------------
  // T5: damping products and moment arm products
  // ---------------------------------------------------------------
  logic               v5_r;
  logic signed [63:0] pdt5_r, pdn5_r, pm1_5_r, pm2_5_r;
  logic signed [31:0] ft5_r, fn5_r, s5_r, c5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    pdt5_r  <= 64'(vtl4_r) * tdamp_s;
    pdn5_r  <= 64'(vnl4_r) * ndamp_s;
    pm1_5_r <= 64'(fn4_r) * 64'(ax4_r);
    pm2_5_r <= 64'(ft4_r) * 64'(sh4_r);
    ft5_r   <= ft4_r;
    fn5_r   <= fn4_r;
    s5_r    <= s4_r;
    c5_r    <= c4_r;
  end

  // ---------------------------------------------------------------
  // T6: total tangential and normal forces, partial moment
  // ---------------------------------------------------------------
  logic signed [31:0] dt_nxt, dn_nxt;
  logic               v6_r;
  logic signed [31:0] p6_r, q6_r, dn6_r, s6_r, c6_r;
  logic signed [63:0] m6_r;

  assign dt_nxt = rodf_pkg::sat32(pdt5_r >>> FRAC_BITS);
  assign dn_nxt = rodf_pkg::sat32(pdn5_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    p6_r  <= rodf_pkg::sat32(64'(ft5_r) + 64'(dt_nxt));
    q6_r  <= rodf_pkg::sat32(64'(fn5_r) + 64'(dn_nxt));
    dn6_r <= dn_nxt;
    m6_r  <= (pm1_5_r >>> FRAC_BITS) - (pm2_5_r >>> FRAC_BITS);
    s6_r  <= s5_r;
    c6_r  <= c5_r;
  end

  // ---------------------------------------------------------------
  // T7: back to the global frame (products)
  // ---------------------------------------------------------------
  logic               v7_r;
  logic signed [63:0] cp7_r, sp7_r, cq7_r, sq7_r, pdl7_r, m7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    cp7_r  <= 64'(c6_r) * 64'(p6_r);
    sp7_r  <= 64'(s6_r) * 64'(p6_r);
    cq7_r  <= 64'(c6_r) * 64'(q6_r);
    sq7_r  <= 64'(s6_r) * 64'(q6_r);
    pdl7_r <= 64'(dn6_r) * length_s;
    m7_r   <= m6_r;
  end

  // ---------------------------------------------------------------
  // T8: add gravity, saturate, present the result for one cycle
  // ---------------------------------------------------------------
  logic signed [63:0] cp, sp, cq, sq;
  rodf_pkg::out_t     out_nxt;

  assign cp = cp7_r >>> 30;
  assign sp = sp7_r >>> 30;
  assign cq = cq7_r >>> 30;
  assign sq = sq7_r >>> 30;

  assign out_nxt.force_node1_x = rodf_pkg::sat32(64'(grav_x_r) + cp - sq);
  assign out_nxt.force_node1_y = rodf_pkg::sat32(64'(grav_y_r) + sp + cq);
  assign out_nxt.moment        = rodf_pkg::sat32(m7_r + (pdl7_r >>> FRAC_BITS));
  assign out_nxt.force_node2_x = rodf_pkg::sat32(64'(grav_x_r) - cp + sq);
  assign out_nxt.force_node2_y = rodf_pkg::sat32(64'(grav_y_r) - sp - cq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v7_r;
    end
    out_data <= out_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/rodf_sincos.sv]
`default_nettype none

module rodf_sincos #(
  parameter int FRAC_BITS = rodf_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] angle,
  output logic                    out_valid,
  output logic signed [31:0]      sin_q,
  output logic signed [31:0]      cos_q
);

  localparam int RN = rodf_pkg::RND_N;

  // Stage 1: angle to phase in 2^-32 turns
  logic signed [63:0] turn_prod;
  logic               v1_r;
  logic [31:0]        phase_r;

  assign turn_prod = 64'(angle) * 64'(rodf_pkg::TURN_PER_RAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    phase_r <= turn_prod[FRAC_BITS+31:FRAC_BITS];
  end

  // Stage 2: fold into the first octant, scale to radians
  logic [29:0] red_nxt;
  logic [63:0] xprod;
  logic        v2_r;
  logic [29:0] x2st_r;
  logic [1:0]  quad2_r;
  logic        swap2_r;

  assign red_nxt = phase_r[29] ? 30'((31'd1 << 30) - 31'(phase_r[29:0])) : phase_r[29:0];
  assign xprod   = 64'(red_nxt) * 64'(rodf_pkg::PI_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    x2st_r  <= xprod[60:31];
    quad2_r <= phase_r[31:30];
    swap2_r <= phase_r[29];
  end

  // Stage 3: square
  logic [59:0] sq;
  logic        v3_r;
  logic [29:0] x3_r;
  logic [29:0] xx3_r;
  logic [1:0]  quad3_r;
  logic        swap3_r;

  assign sq = 60'(x2st_r) * 60'(x2st_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    x3_r    <= x2st_r;
    xx3_r   <= sq[59:30];
    quad3_r <= quad2_r;
    swap3_r <= swap2_r;
  end

  // Stage 4: leading divide of both series; then the rounds
  logic        v_r    [0:RN];
  logic [29:0] qs_r   [0:RN];
  logic [29:0] qc_r   [0:RN];
  logic [29:0] x_r    [0:RN];
  logic [29:0] xx_r   [0:RN];
  logic [1:0]  quad_r [0:RN];
  logic        swap_r [0:RN];
  logic [60:0] q0s;
  logic [60:0] q0c;

  assign q0s = (61'(xx3_r) * 61'(rodf_pkg::S0_M)) >> rodf_pkg::S0_SH;
  assign q0c = (61'(xx3_r) * 61'(rodf_pkg::C0_M)) >> rodf_pkg::C0_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= v3_r;
    end
    qs_r[0]   <= q0s[29:0];
    qc_r[0]   <= q0c[29:0];
    x_r[0]    <= x3_r;
    xx_r[0]   <= xx3_r;
    quad_r[0] <= quad3_r;
    swap_r[0] <= swap3_r;
  end

  for (genvar g = 0; g < RN; g++) begin : g_rnd
    logic [29:0] sop;
    logic [60:0] ps_prod;
    logic [60:0] pc_prod;
    logic        pv_r;
    logic [29:0] ps_r;
    logic [29:0] pc_r;
    logic [29:0] px_r;
    logic [29:0] pxx_r;
    logic [1:0]  pquad_r;
    logic        pswap_r;
    logic [60:0] ds_prod;
    logic [60:0] dc_prod;

    // Last sine round multiplies by x instead of x^2
    assign sop     = (g == RN - 1) ? x_r[g] : xx_r[g];
    assign ps_prod = 61'(sop) * 61'(rodf_pkg::TRIG_ONE - 31'(qs_r[g]));
    assign pc_prod = 61'(xx_r[g]) * 61'(rodf_pkg::TRIG_ONE - 31'(qc_r[g]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r <= 1'b0;
      end else begin
        pv_r <= v_r[g];
      end
      ps_r    <= ps_prod[59:30];
      pc_r    <= pc_prod[59:30];
      px_r    <= x_r[g];
      pxx_r   <= xx_r[g];
      pquad_r <= quad_r[g];
      pswap_r <= swap_r[g];
    end

    assign ds_prod = (61'(ps_r) * 61'(rodf_pkg::SIN_M[g])) >> rodf_pkg::SIN_SH[g];
    assign dc_prod = (61'(pc_r) * 61'(rodf_pkg::COS_M[g])) >> rodf_pkg::COS_SH[g];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= pv_r;
      end
      qs_r[g+1]   <= ds_prod[29:0];
      qc_r[g+1]   <= dc_prod[29:0];
      x_r[g+1]    <= px_r;
      xx_r[g+1]   <= pxx_r;
      quad_r[g+1] <= pquad_r;
      swap_r[g+1] <= pswap_r;
    end
  end

  // Final stage: undo the octant fold and the quadrant
  logic signed [31:0] ps_fin;
  logic signed [31:0] pc_fin;
  logic signed [31:0] s0;
  logic signed [31:0] c0;
  logic signed [31:0] sin_nxt;
  logic signed [31:0] cos_nxt;

  assign ps_fin = $signed({2'b00, qs_r[RN]});
  assign pc_fin = $signed(32'(rodf_pkg::TRIG_ONE) - {2'b00, qc_r[RN]});
  assign s0     = swap_r[RN] ? pc_fin : ps_fin;
  assign c0     = swap_r[RN] ? ps_fin : pc_fin;

  always_comb begin
    case (quad_r[RN])
      2'd0: begin
        sin_nxt = s0;
        cos_nxt = c0;
      end
      2'd1: begin
        sin_nxt = c0;
        cos_nxt = -s0;
      end
      2'd2: begin
        sin_nxt = -s0;
        cos_nxt = -c0;
      end
      default: begin
        sin_nxt = -c0;
        cos_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[RN];
    end
    sin_q <= sin_nxt;
    cos_q <= cos_nxt;
  end

endmodule

`default_nettype wire
